@@ design/spmq_pkg.sv @@
// ----------------------------------------------------------------------------
// spmq_pkg
// Types and fixed field widths shared by the multi-queue node pool.
// ----------------------------------------------------------------------------
package spmq_pkg;

  localparam int QSEL_W  = 2;
  localparam int ID_W    = 32;
  localparam int GRADE_W = 8;

  typedef enum logic {
    FN_APPEND = 1'b0,
    FN_REMOVE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [GRADE_W-1:0] grade;
  } rec_t;

endpackage

@@ design/spmq_if.sv @@
// ----------------------------------------------------------------------------
// spmq_if
// Valid/ready channels for operations into and results out of the queue pool.
// ----------------------------------------------------------------------------
interface spmq_in_if;
  import spmq_pkg::*;

  logic                 valid;
  logic                 ready;
  func_t                func;
  logic [QSEL_W-1:0]    queue_sel;
  logic [ID_W-1:0]      rec_id;
  logic [GRADE_W-1:0]   rec_grade;

  modport source (output valid, func, queue_sel, rec_id, rec_grade, input ready);
  modport sink   (input valid, func, queue_sel, rec_id, rec_grade, output ready);
endinterface

interface spmq_out_if;
  import spmq_pkg::*;

  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [QSEL_W-1:0]    out_queue;
  logic [ID_W-1:0]      out_id;
  logic [GRADE_W-1:0]   out_grade;

  modport source (output valid, status, out_queue, out_id, out_grade, input ready);
  modport sink   (input valid, status, out_queue, out_id, out_grade, output ready);
endinterface

@@ design/shared_pool_multi_queue.sv @@
// The input register holds an operation once it transfers in; the result
// register loads when that operation executes and the result side is free.
// Throughput: one operation per cycle while the result side takes transfers;
// the record memory does one read and the link memory two reads per cycle,
// addressed ahead of use from the next-state pointers, with one write each.
// Reset: queue pointers, free list head, free count and handshake state clear;
// node storage is not cleared, a fill mark stands in for the initial links.
// ----------------------------------------------------------------------------
// shared_pool_multi_queue
// Several FIFO queues of records linked through one shared pool of nodes.
// ----------------------------------------------------------------------------
module shared_pool_multi_queue #(
  parameter int NUM_QUEUES = 3,
  parameter int POOL_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  spmq_in_if.sink     in_ch,
  spmq_out_if.source  out_ch
);
  import spmq_pkg::*;

  localparam int PTR_W  = $clog2(POOL_DEPTH);
  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(POOL_DEPTH);
  localparam logic [PTR_W-1:0] LAST_NODE = PTR_W'(POOL_DEPTH - 1);

  // input register
  logic                in_valid_r;
  func_t               in_func_r;
  logic [QSEL_W-1:0]   in_sel_r;
  logic [ID_W-1:0]     in_id_r;
  logic [GRADE_W-1:0]  in_grade_r;

  // output register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [QSEL_W-1:0]   out_queue_r;
  logic [ID_W-1:0]     out_id_r;
  logic [GRADE_W-1:0]  out_grade_r;

  // queue and free list state
  logic [PTR_W-1:0]    head_r     [NUM_QUEUES];
  logic [PTR_W-1:0]    head_nxt   [NUM_QUEUES];
  logic [PTR_W-1:0]    tail_r     [NUM_QUEUES];
  logic [PTR_W-1:0]    tail_nxt   [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] nonempty_r, nonempty_nxt;
  logic [PTR_W-1:0]    free_head_r, free_head_nxt;
  logic [CNT_W-1:0]    free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]    hwm_r, hwm_nxt;

  // node memories
  rec_t                node_rec_mem  [POOL_DEPTH];
  logic [PTR_W-1:0]    node_next_mem [POOL_DEPTH];
  rec_t                rec_rd_r;
  logic [PTR_W-1:0]    hd_next_rd_r;
  logic [PTR_W-1:0]    fr_next_rd_r;

  logic                rec_we;
  logic [PTR_W-1:0]    rec_waddr;
  rec_t                rec_wdata;
  logic                nxt_we;
  logic [PTR_W-1:0]    nxt_waddr;
  logic [PTR_W-1:0]    nxt_wdata;
  logic [PTR_W-1:0]    hd_raddr;

  logic                fire;
  logic                in_fire;
  logic                valid_q;
  logic [QIDX_W-1:0]   qi;
  logic [QSEL_W-1:0]   sel_ahead;
  logic                fresh;
  status_t             status_nxt;
  rec_t                res_rec;

  assign fire     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || fire;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign valid_q  = int'(in_sel_r) < NUM_QUEUES;
  assign qi       = QIDX_W'(in_sel_r);
  assign fresh    = (CNT_W'(free_head_r) == hwm_r);

  // execute the operation held in the input register
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    nonempty_nxt  = nonempty_r;
    free_head_nxt = free_head_r;
    free_cnt_nxt  = free_cnt_r;
    hwm_nxt       = hwm_r;
    status_nxt    = ST_OK;
    res_rec       = '0;
    rec_we        = 1'b0;
    rec_waddr     = free_head_r;
    rec_wdata     = '{id: in_id_r, grade: in_grade_r};
    nxt_we        = 1'b0;
    nxt_waddr     = free_head_r;
    nxt_wdata     = free_head_r;
    if (fire) begin
      if (in_func_r == FN_APPEND) begin
        if (!valid_q || free_cnt_r == '0) begin
          status_nxt = ST_FULL;
        end else begin
          // never-used nodes link to the following index
          if (fresh) begin
            free_head_nxt = (free_head_r == LAST_NODE) ? '0 : free_head_r + 1'b1;
            hwm_nxt       = hwm_r + 1'b1;
          end else begin
            free_head_nxt = fr_next_rd_r;
          end
          free_cnt_nxt = free_cnt_r - 1'b1;
          rec_we       = 1'b1;
          if (nonempty_r[qi]) begin
            nxt_we    = 1'b1;
            nxt_waddr = tail_r[qi];
            nxt_wdata = free_head_r;
          end else begin
            head_nxt[qi] = free_head_r;
          end
          tail_nxt[qi]     = free_head_r;
          nonempty_nxt[qi] = 1'b1;
        end
      end else begin
        if (!valid_q || !nonempty_r[qi]) begin
          status_nxt = ST_EMPTY;
        end else begin
          res_rec = rec_rd_r;
          if (head_r[qi] == tail_r[qi]) begin
            nonempty_nxt[qi] = 1'b0;
          end else begin
            head_nxt[qi] = hd_next_rd_r;
          end
          // push the freed node on the free list
          nxt_we        = 1'b1;
          nxt_waddr     = head_r[qi];
          nxt_wdata     = free_head_r;
          free_head_nxt = head_r[qi];
          free_cnt_nxt  = free_cnt_r + 1'b1;
        end
      end
    end
  end

  // read the head node of the queue the next operation addresses
  always_comb begin
    sel_ahead = in_fire ? in_ch.queue_sel : in_sel_r;
    hd_raddr  = '0;
    if (int'(sel_ahead) < NUM_QUEUES) begin
      hd_raddr = head_nxt[QIDX_W'(sel_ahead)];
    end
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      node_rec_mem[rec_waddr] <= rec_wdata;
    end
    if (nxt_we) begin
      node_next_mem[nxt_waddr] <= nxt_wdata;
    end
    // forward a write that lands on the address being read
    rec_rd_r     <= (rec_we && rec_waddr == hd_raddr) ? rec_wdata : node_rec_mem[hd_raddr];
    hd_next_rd_r <= (nxt_we && nxt_waddr == hd_raddr) ? nxt_wdata
                                                       : node_next_mem[hd_raddr];
    fr_next_rd_r <= (nxt_we && nxt_waddr == free_head_nxt) ? nxt_wdata
                                                            : node_next_mem[free_head_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '{default: '0};
      tail_r      <= '{default: '0};
      nonempty_r  <= '0;
      free_head_r <= '0;
      free_cnt_r  <= DEPTH_C;
      hwm_r       <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      nonempty_r  <= nonempty_nxt;
      free_head_r <= free_head_nxt;
      free_cnt_r  <= free_cnt_nxt;
      hwm_r       <= hwm_nxt;
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_func_r  <= in_ch.func;
      in_sel_r   <= in_ch.queue_sel;
      in_id_r    <= in_ch.rec_id;
      in_grade_r <= in_ch.rec_grade;
    end
    if (fire) begin
      out_status_r <= status_nxt;
      out_queue_r  <= in_sel_r;
      out_id_r     <= res_rec.id;
      out_grade_r  <= res_rec.grade;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_queue = out_queue_r;
  assign out_ch.out_id    = out_id_r;
  assign out_ch.out_grade = out_grade_r;

`ifndef NO_ASSERTIONS
  // pool exhausted only once every node has been handed out at least once
  a_empty_pool_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (free_cnt_r == '0) |-> (hwm_r == DEPTH_C))
    else $error("free count zero before all nodes were used");

  // nodes never handed out are always counted free
  a_fresh_counted: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, free_cnt_r} + {1'b0, hwm_r}) >= {1'b0, DEPTH_C})
    else $error("free count below number of untouched nodes");

  // a successful remove always leaves a node on the free list
  a_remove_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_func_r == FN_REMOVE && status_nxt == ST_OK) |=> (free_cnt_r != '0))
    else $error("remove did not return a node to the pool");
`endif

endmodule
